>>> rtl/core/ffa_pkg.sv
// Shared types and constants of the first-fit block allocator.
package ffa_pkg;

    localparam int SIZE_W  = 11;
    localparam int START_W = 7;
    localparam int ADDR_W  = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [SIZE_W-1:0]  size_bytes;
        logic [START_W-1:0] start_block;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] byte_address;
    } t_rsp;

endpackage

>>> rtl/core/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ffa_blkdiv.sv
// Bit-serial restoring divider by a constant, one quotient bit per cycle.
module ffa_blkdiv #(
    parameter int DIVISOR = 8,
    parameter int DVD_W   = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int R_W   = $clog2(DIVISOR) + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [R_W-1:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [R_W:0]     w_rem_sh;
    logic             w_qbit;
    logic [R_W:0]     w_rem_sub;

    // shift in the next dividend bit and try one subtract
    always_comb begin
        w_rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        w_qbit    = (w_rem_sh >= (R_W+1)'(DIVISOR));
        w_rem_sub = w_qbit ? (w_rem_sh - (R_W+1)'(DIVISOR)) : w_rem_sh;
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], w_qbit};
            r_rem <= R_W'(w_rem_sub);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

>>> rtl/core/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: control sequencer and occupancy map.
//
//  channel   dir  handshake                     payload
//  request   in   i_start, accepted if !o_busy  i_req (ffa_pkg::t_req)
//  result    out  o_done, one-cycle strobe      o_rsp (ffa_pkg::t_rsp)
//
// Every request yields one result. The block count comes from the serial
// divider; an allocate then scans the map one bit per cycle and marks the
// run one block per cycle; a free clears its run one block per cycle. After
// reset a clearing pass holds o_busy high. The result cannot be stalled;
// o_busy is low again in the cycle the strobe is shown.
module first_fit_block_allocator_top #(
    parameter int TOTAL_BLOCKS = 128,
    parameter int BLOCK_BYTES  = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ffa_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output ffa_pkg::t_rsp o_rsp
);

    import ffa_pkg::*;

    localparam int BLK_W = $clog2(TOTAL_BLOCKS);
    localparam int CNT_W = BLK_W + 1;
    localparam int DVD_W = SIZE_W + $clog2(BLOCK_BYTES + 1);
    localparam int CMP_W = ((DVD_W > CNT_W) ? DVD_W : CNT_W) + 1;
    localparam logic [ADDR_W-1:0] BB_ADDR = ADDR_W'(BLOCK_BYTES);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic               r_op, n_op;
    logic [START_W-1:0] r_start, n_start;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_scan_idx, n_scan_idx;
    logic               r_chk_vld, n_chk_vld;
    logic [CNT_W-1:0]   r_chk_idx, n_chk_idx;
    logic [CNT_W-1:0]   r_run_len, n_run_len;
    logic [CNT_W-1:0]   r_run_start, n_run_start;
    logic [ADDR_W-1:0]  r_run_addr, n_run_addr;
    logic [ADDR_W-1:0]  r_chk_addr, n_chk_addr;
    logic [CNT_W-1:0]   r_mark_idx, n_mark_idx;
    logic [CNT_W-1:0]   r_end, n_end;
    logic               r_wr_bit, n_wr_bit;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_done, n_done;
    t_rsp               r_rsp, n_rsp;

    logic               w_div_start;
    logic               w_div_done;
    logic [DVD_W-1:0]   w_quot;
    logic [DVD_W-1:0]   w_len;
    logic [CMP_W-1:0]   w_len_ext;
    logic [CMP_W-1:0]   w_end_sum;
    logic               w_ram_we;
    logic               w_ram_wdata;
    logic               w_used;
    logic [CNT_W-1:0]   w_run_inc;

    // block count: ceil(size / BLOCK_BYTES) on the serial divider
    assign w_div_start = (r_state == S_IDLE) && i_start;

    ffa_blkdiv #(
        .DIVISOR (BLOCK_BYTES),
        .DVD_W   (DVD_W)
    ) u_blkdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (DVD_W'(i_req.size_bytes) + DVD_W'(BLOCK_BYTES - 1)),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // occupancy map, one bit per block
    assign w_ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign w_ram_wdata = (r_state == S_WRITE) ? r_wr_bit : 1'b0;

    ffa_ram #(
        .WIDTH (1),
        .DEPTH (TOTAL_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_mark_idx[BLK_W-1:0]),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_scan_idx[BLK_W-1:0]),
        .o_rdata (w_used)
    );

    // zero bytes still takes one block
    assign w_len     = (w_quot == '0) ? DVD_W'(1) : w_quot;
    assign w_len_ext = CMP_W'(w_len);
    assign w_end_sum = CMP_W'(r_start) + w_len_ext;
    assign w_run_inc = r_run_len + CNT_W'(1);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_start     = r_start;
        n_len       = r_len;
        n_scan_idx  = r_scan_idx;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        n_run_addr  = r_run_addr;
        n_chk_addr  = r_chk_addr;
        n_mark_idx  = r_mark_idx;
        n_end       = r_end;
        n_wr_bit    = r_wr_bit;
        n_addr      = r_addr;
        n_done      = 1'b0;
        n_rsp       = r_rsp;

        case (r_state)
            S_CLEAR: begin
                n_mark_idx = r_mark_idx + CNT_W'(1);
                if (r_mark_idx == CNT_W'(TOTAL_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_req.operation;
                    n_start = i_req.start_block;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_op == OP_ALLOC) begin
                        if (w_len_ext > CMP_W'(TOTAL_BLOCKS)) begin
                            // needs more blocks than exist
                            n_done  = 1'b1;
                            n_rsp   = '{granted: 1'b0, byte_address: '0};
                            n_state = S_IDLE;
                        end else begin
                            n_len       = CNT_W'(w_len);
                            n_scan_idx  = '0;
                            n_run_len   = '0;
                            n_run_start = '0;
                            n_run_addr  = '0;
                            n_chk_addr  = '0;
                            n_wr_bit    = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end else if (CMP_W'(r_start) >= CMP_W'(TOTAL_BLOCKS)) begin
                        // free out of range clears nothing
                        n_done  = 1'b1;
                        n_rsp   = '{granted: 1'b1, byte_address: '0};
                        n_state = S_IDLE;
                    end else begin
                        n_mark_idx = CNT_W'(r_start);
                        n_end      = (w_end_sum > CMP_W'(TOTAL_BLOCKS)) ?
                                     CNT_W'(TOTAL_BLOCKS) : CNT_W'(w_end_sum);
                        n_wr_bit   = 1'b0;
                        n_addr     = '0;
                        n_state    = S_WRITE;
                    end
                end
            end
            S_SCAN: begin
                // issue one map read per cycle, check the previous one
                if (r_scan_idx < CNT_W'(TOTAL_BLOCKS)) begin
                    n_chk_vld  = 1'b1;
                    n_chk_idx  = r_scan_idx;
                    n_scan_idx = r_scan_idx + CNT_W'(1);
                end
                if (r_chk_vld) begin
                    n_chk_addr = r_chk_addr + BB_ADDR;
                    if (!w_used && (w_run_inc == r_len)) begin
                        n_chk_vld  = 1'b0;
                        n_mark_idx = r_run_start;
                        n_end      = r_run_start + r_len;
                        n_addr     = r_run_addr;
                        n_state    = S_WRITE;
                    end else begin
                        if (w_used) begin
                            n_run_len   = '0;
                            n_run_start = r_chk_idx + CNT_W'(1);
                            n_run_addr  = r_chk_addr + BB_ADDR;
                        end else begin
                            n_run_len = w_run_inc;
                        end
                        if (r_chk_idx == CNT_W'(TOTAL_BLOCKS - 1)) begin
                            // no fitting run
                            n_chk_vld = 1'b0;
                            n_done    = 1'b1;
                            n_rsp     = '{granted: 1'b0, byte_address: '0};
                            n_state   = S_IDLE;
                        end
                    end
                end
            end
            S_WRITE: begin
                // mark or clear the run one block per cycle
                n_mark_idx = r_mark_idx + CNT_W'(1);
                if (n_mark_idx == r_end) begin
                    n_done  = 1'b1;
                    n_rsp   = '{granted: 1'b1, byte_address: r_addr};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_chk_vld  <= 1'b0;
            r_done     <= 1'b0;
            r_mark_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_chk_vld  <= n_chk_vld;
            r_done     <= n_done;
            r_mark_idx <= n_mark_idx;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_start     <= n_start;
        r_len       <= n_len;
        r_scan_idx  <= n_scan_idx;
        r_chk_idx   <= n_chk_idx;
        r_run_len   <= n_run_len;
        r_run_start <= n_run_start;
        r_run_addr  <= n_run_addr;
        r_chk_addr  <= n_chk_addr;
        r_end       <= n_end;
        r_wr_bit    <= n_wr_bit;
        r_addr      <= n_addr;
        r_rsp       <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.granted) |-> (o_rsp.byte_address == '0))
        else $error("failed allocation carries an address");

    a_free_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_op == OP_FREE)) |-> (o_rsp.granted && (o_rsp.byte_address == '0)))
        else $error("free result not granted with zero address");

endmodule

>>> tb/tb_first_fit_block_allocator_top.sv
// Self-checking testbench for the first-fit block allocator: corner cases and random traffic.
module tb_first_fit_block_allocator_top;
    import ffa_pkg::*;

    localparam int NUM_BLOCKS   = 128;
    localparam int BLK_BYTES    = 8;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        int unsigned first_blk;
        int unsigned nbytes;
    } t_region;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    // occupancy map as the block should hold it
    bit [NUM_BLOCKS-1:0] occupancy;
    t_rsp                grant_q[$];
    t_region             live_regions[$];
    int                  error_count = 0;
    int unsigned         cycle_count = 0;

    first_fit_block_allocator_top #(
        .TOTAL_BLOCKS(NUM_BLOCKS),
        .BLOCK_BYTES (BLK_BYTES)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     grant_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // blocks needed for a byte count; zero still takes one block
    function automatic int unsigned blocks_needed(input int unsigned nbytes);
        int unsigned n;
        n = (nbytes + BLK_BYTES - 1) / BLK_BYTES;
        return (n == 0) ? 1 : n;
    endfunction

    // apply one request to the occupancy map and return the result it should give
    function automatic t_rsp predict_grant(input t_req r);
        int unsigned len;
        int unsigned stop;
        bit          fits;
        t_rsp        rsp;
        rsp = '0;
        len = blocks_needed(32'(r.size_bytes));
        if (r.operation == OP_ALLOC) begin
            if (len <= NUM_BLOCKS) begin
                for (int unsigned s = 0; s + len <= NUM_BLOCKS; s++) begin
                    fits = 1'b1;
                    for (int unsigned k = s; k < s + len; k++)
                        if (occupancy[k]) fits = 1'b0;
                    if (fits) begin
                        for (int unsigned k = s; k < s + len; k++) occupancy[k] = 1'b1;
                        rsp.granted      = 1'b1;
                        rsp.byte_address = ADDR_W'(s * BLK_BYTES);
                        break;
                    end
                end
            end
        end else begin
            if (r.start_block < NUM_BLOCKS) begin
                stop = 32'(r.start_block) + len;
                if (stop > NUM_BLOCKS) stop = NUM_BLOCKS;
                for (int unsigned k = 32'(r.start_block); k < stop; k++) occupancy[k] = 1'b0;
            end
            rsp.granted = 1'b1;
        end
        return rsp;
    endfunction

    // result checker: each strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (grant_q.size() == 0) begin
                report_error($sformatf("unexpected result granted=%0b addr=%0d",
                                       o_rsp.granted, o_rsp.byte_address));
            end else begin
                want = grant_q.pop_front();
                if (o_rsp.granted !== want.granted)
                    report_error($sformatf("granted got %0b expected %0b",
                                           o_rsp.granted, want.granted));
                if (o_rsp.byte_address !== want.byte_address)
                    report_error($sformatf("byte_address got %0d expected %0d",
                                           o_rsp.byte_address, want.byte_address));
            end
        end
    end

    // drive one item at a falling edge, hold until accepted; start stays high on return
    task automatic issue_request(input t_req r, output t_rsp want);
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        want = predict_grant(r);
        grant_q.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic run_item(input logic op, input int unsigned nbytes,
                            input int unsigned first_blk);
        t_req r;
        t_rsp want;
        r.operation   = op;
        r.size_bytes  = SIZE_W'(nbytes);
        r.start_block = START_W'(first_blk);
        issue_request(r, want);
    endtask

    // sender idle, start held low; n must be at least one
    task automatic pause(input int unsigned n);
        i_start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // hold off until every pending result has come back
    task automatic drain();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (grant_q.size() != 0) @(negedge i_clk);
    endtask

    // rounding, oversize requests, first fit into a hole, full memory
    task automatic test_alloc_edges();
        run_item(OP_ALLOC, 0, 0);          // one block at 0
        run_item(OP_ALLOC, 1, 7'h7F);      // start field ignored, block 1
        run_item(OP_ALLOC, 8, 0);          // exactly one block
        run_item(OP_ALLOC, 9, 0);          // rounds up to two blocks
        run_item(OP_ALLOC, 1025, 0);       // one block too many
        run_item(OP_ALLOC, 2047, 7'h55);   // largest size field
        run_item(OP_FREE, 8, 1);           // punch a hole at block 1
        run_item(OP_ALLOC, 3, 0);          // lands in the hole
        run_item(OP_FREE, 2047, 0);        // clears to the end
        run_item(OP_ALLOC, 1024, 0);       // whole memory
        run_item(OP_ALLOC, 0, 0);          // nothing left
        drain();
    endtask

    // frees past the end, of free blocks, and a run ending at the last block
    task automatic test_free_edges();
        run_item(OP_FREE, 16, 127);        // last block only
        run_item(OP_ALLOC, 16, 0);         // no run of two
        run_item(OP_ALLOC, 5, 0);          // last block
        run_item(OP_FREE, 0, 0);           // zero size frees one block
        run_item(OP_FREE, 0, 3);
        run_item(OP_FREE, 0, 3);           // already free
        run_item(OP_FREE, 1024, 0);        // clear everything
        run_item(OP_FREE, 1024, 0);
        run_item(OP_ALLOC, 1016, 0);       // 127 blocks
        run_item(OP_ALLOC, 8, 0);          // fills the gap at the top
        run_item(OP_FREE, 1024, 0);
        drain();
    endtask

    function automatic int unsigned pick_size();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 60) return $urandom_range(0, 64);
        if (p < 85) return $urandom_range(65, 256);
        if (p < 95) return $urandom_range(257, 1024);
        return $urandom_range(1025, 2047);
    endfunction

    // mostly alloc/free pairs on live regions, with stray frees mixed in
    task automatic test_random_mix();
        t_req        r;
        t_rsp        want;
        t_region     reg_entry;
        int unsigned pick;
        int unsigned idx;
        int unsigned burst_left;
        burst_left = $urandom_range(1, 8);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            r.start_block = START_W'($urandom_range(0, NUM_BLOCKS - 1));
            if (n % 500 == 499) begin
                r.operation  = OP_FREE;
                r.size_bytes = SIZE_W'(1024);
                r.start_block = '0;
                live_regions.delete();
            end else if (live_regions.size() == 0 || pick < 45) begin
                r.operation  = OP_ALLOC;
                r.size_bytes = SIZE_W'(pick_size());
            end else if (pick < 85) begin
                idx = $urandom_range(0, live_regions.size() - 1);
                reg_entry     = live_regions[idx];
                live_regions.delete(idx);
                r.operation   = OP_FREE;
                r.size_bytes  = SIZE_W'(reg_entry.nbytes);
                r.start_block = START_W'(reg_entry.first_blk);
            end else if (pick < 95) begin
                r.operation  = OP_FREE;
                r.size_bytes = SIZE_W'($urandom_range(0, 2047));
            end else begin
                r.operation  = OP_ALLOC;
                r.size_bytes = SIZE_W'($urandom_range(0, 2047));
            end

            issue_request(r, want);
            if (r.operation == OP_ALLOC && want.granted) begin
                reg_entry.first_blk = 32'(want.byte_address) / BLK_BYTES;
                reg_entry.nbytes    = 32'(r.size_bytes);
                live_regions.push_back(reg_entry);
            end

            // sender bursts and gaps
            if (n == RANDOM_ITEMS / 2) begin
                drain();
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) == 0) pause($urandom_range(20, 300));
                    else pause($urandom_range(1, 19));
                    if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(30, 80);
                    else burst_left = $urandom_range(1, 8);
                end
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req   = '0;
        occupancy = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_alloc_edges();
        test_free_edges();
        test_random_mix();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ffa_pkg.sv
rtl/core/ffa_ram.sv
rtl/core/ffa_blkdiv.sv
rtl/core/first_fit_block_allocator_top.sv
tb/tb_first_fit_block_allocator_top.sv
